// ===== rtl/csvft_pkg.sv =====
package csvft_pkg;

	// parse phases
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_FIELD      = 3'd1;
	localparam logic [2:0] PH_FIELD_ESC  = 3'd2;
	localparam logic [2:0] PH_QUOTED     = 3'd3;
	localparam logic [2:0] PH_QUOTED_ESC = 3'd4;
	localparam logic [2:0] PH_QUOTE_SEEN = 3'd5;

	// token kinds
	localparam logic [1:0] KIND_DATA      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_REC_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR     = 2'd3;

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	// register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_DELIMITER = 2'd0;
	localparam logic [1:0] REG_QUOTE     = 2'd1;
	localparam logic [1:0] REG_ESCAPE    = 2'd2;

	localparam logic [7:0] DELIMITER_RST = 8'd44;
	localparam logic [7:0] QUOTE_RST     = 8'd34;
	localparam logic [7:0] ESCAPE_RST    = 8'd0;

	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] quote;
		logic [7:0] esc;
	} cfg_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] kind;
		logic [7:0] data;
	} token_t;

endpackage

// ===== rtl/csvft_cfg_regs.sv =====
module csvft_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csvft_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output csvft_pkg::cfg_t              cfg
);

	logic [7:0] delim_q;
	logic [7:0] quote_q;
	logic [7:0] esc_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[csvft_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= csvft_pkg::DELIMITER_RST;
			quote_q <= csvft_pkg::QUOTE_RST;
			esc_q   <= csvft_pkg::ESCAPE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				csvft_pkg::REG_DELIMITER: delim_q <= pwdata[7:0];
				csvft_pkg::REG_QUOTE:     quote_q <= pwdata[7:0];
				csvft_pkg::REG_ESCAPE:    esc_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			csvft_pkg::REG_DELIMITER: prdata = {24'd0, delim_q};
			csvft_pkg::REG_QUOTE:     prdata = {24'd0, quote_q};
			csvft_pkg::REG_ESCAPE:    prdata = {24'd0, esc_q};
			default:                  prdata = 32'd0;
		endcase
	end

	assign cfg = '{delim: delim_q, quote: quote_q, esc: esc_q};

endmodule

// ===== rtl/csvft_step.sv =====
module csvft_step (
	input  logic              [2:0] phase,
	input  logic              [7:0] in_byte,
	input  logic                    end_of_input,
	input  csvft_pkg::cfg_t         cfg,
	output logic              [2:0] phase_nxt,
	output csvft_pkg::token_t       token
);

	logic       f_eoi;
	logic [2:0] f_phase;
	logic       f_vld;
	logic [1:0] f_kind;
	logic [7:0] f_data;

	// field context: quote, delimiter, newline or end, escape, data
	always_comb begin
		f_eoi = end_of_input && (phase != csvft_pkg::PH_IDLE);
		if (!f_eoi && in_byte == cfg.quote) begin
			f_phase = csvft_pkg::PH_QUOTED;
			f_vld   = 1'b0;
			f_kind  = csvft_pkg::KIND_DATA;
			f_data  = 8'd0;
		end else if (!f_eoi && in_byte == cfg.delim) begin
			f_phase = csvft_pkg::PH_FIELD;
			f_vld   = 1'b1;
			f_kind  = csvft_pkg::KIND_FIELD_END;
			f_data  = 8'd0;
		end else if (f_eoi || in_byte == csvft_pkg::NEWLINE_BYTE) begin
			f_phase = csvft_pkg::PH_IDLE;
			f_vld   = 1'b1;
			f_kind  = csvft_pkg::KIND_REC_END;
			f_data  = 8'd0;
		end else if (in_byte == cfg.esc) begin
			f_phase = csvft_pkg::PH_FIELD_ESC;
			f_vld   = 1'b0;
			f_kind  = csvft_pkg::KIND_DATA;
			f_data  = 8'd0;
		end else begin
			f_phase = csvft_pkg::PH_FIELD;
			f_vld   = 1'b1;
			f_kind  = csvft_pkg::KIND_DATA;
			f_data  = in_byte;
		end
	end

	always_comb begin
		phase_nxt = f_phase;
		token     = '{vld: f_vld, kind: f_kind, data: f_data};
		case (phase)
			csvft_pkg::PH_FIELD: ;
			csvft_pkg::PH_FIELD_ESC, csvft_pkg::PH_QUOTED_ESC: begin
				if (end_of_input) begin
					phase_nxt = csvft_pkg::PH_IDLE;
					token     = '{vld: 1'b1, kind: csvft_pkg::KIND_ERROR, data: 8'd0};
				end else begin
					phase_nxt = (phase == csvft_pkg::PH_FIELD_ESC) ?
						csvft_pkg::PH_FIELD : csvft_pkg::PH_QUOTED;
					token     = '{vld: 1'b1, kind: csvft_pkg::KIND_DATA, data: in_byte};
				end
			end
			csvft_pkg::PH_QUOTED: begin
				if (end_of_input) begin
					phase_nxt = csvft_pkg::PH_IDLE;
					token     = '{vld: 1'b1, kind: csvft_pkg::KIND_ERROR, data: 8'd0};
				end else if (in_byte == cfg.quote) begin
					phase_nxt = csvft_pkg::PH_QUOTE_SEEN;
					token     = '{vld: 1'b0, kind: csvft_pkg::KIND_DATA, data: 8'd0};
				end else if (in_byte == cfg.esc) begin
					phase_nxt = csvft_pkg::PH_QUOTED_ESC;
					token     = '{vld: 1'b0, kind: csvft_pkg::KIND_DATA, data: 8'd0};
				end else begin
					phase_nxt = csvft_pkg::PH_QUOTED;
					token     = '{vld: 1'b1, kind: csvft_pkg::KIND_DATA, data: in_byte};
				end
			end
			csvft_pkg::PH_QUOTE_SEEN: begin
				// doubled quote gives a literal quote, anything else closes the section
				if (!end_of_input && in_byte == cfg.quote) begin
					phase_nxt = csvft_pkg::PH_QUOTED;
					token     = '{vld: 1'b1, kind: csvft_pkg::KIND_DATA, data: in_byte};
				end
			end
			default: begin
				// idle and unused codes: end mark gives nothing
				if (end_of_input) begin
					phase_nxt = csvft_pkg::PH_IDLE;
					token     = '{vld: 1'b0, kind: csvft_pkg::KIND_DATA, data: 8'd0};
				end
			end
		endcase
	end

endmodule

// ===== rtl/csv_field_tokenizer_unit.sv =====
// An accepted item waits in the input register; its token, if any, then goes to the result register.
// Throughput: one item per cycle while out_stall is low; the phase register closes its
// loop through a single step of compares, so back-to-back items never wait on each other.
// Reset (arst_n low, asynchronous): phase goes idle, both valid flags clear,
// the delimiter, quote and escape registers return to comma, double quote and NUL.
module csv_field_tokenizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// byte stream in
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   in_byte,
	input  logic                         end_of_input,
	// tokens out
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   token_kind,
	output logic [7:0]                   out_byte,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csvft_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	csvft_pkg::cfg_t   cfg;
	csvft_pkg::token_t token;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	logic [2:0] phase_q;
	logic [2:0] phase_nxt;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;

	logic       out_adv;
	logic       step_go;
	logic       in_take;

	csvft_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The output register is free when empty or when its token leaves this cycle.
	assign out_adv = !out_valid_q || !out_stall;
	// The item in the input register is processed whenever the output can take it;
	// an item that makes no token simply drops out of the pipe.
	assign step_go  = valid_s1 && out_adv;
	// Hold the input side only while a loaded input register cannot move on.
	assign in_stall = valid_s1 && !out_adv;
	assign in_take  = in_valid && !in_stall;

	csvft_step u_step (
		.phase        (phase_q),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.cfg          (cfg),
		.phase_nxt    (phase_nxt),
		.token        (token)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// phase advances once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= csvft_pkg::PH_IDLE;
		end else if (step_go) begin
			phase_q <= phase_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= step_go && token.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (step_go && token.vld) begin
			kind_q <= token.kind;
			data_q <= token.data;
		end
	end

	assign out_valid  = out_valid_q;
	assign token_kind = kind_q;
	assign out_byte   = data_q;

endmodule

// ===== rtl/csvft_checker.sv =====
module csvft_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [1:0]                   token_kind,
	input logic [7:0]                   out_byte,
	input logic                         psel,
	input logic                         penable,
	input logic                         pwrite,
	input logic [csvft_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                  pwdata,
	input logic [31:0]                  prdata
);

	logic wr_delim;
	assign wr_delim = psel && penable && pwrite &&
		(paddr == {csvft_pkg::REG_DELIMITER, 2'b00});

	// a stalled token stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(out_byte))
		else $error("stalled token changed");

	// only data tokens carry a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind != csvft_pkg::KIND_DATA) |-> out_byte == 8'd0)
		else $error("non-data token with nonzero byte");

	// delimiter write is seen on a following read
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		wr_delim |=> !(psel && !pwrite && paddr == {csvft_pkg::REG_DELIMITER, 2'b00}) ||
			prdata[7:0] == $past(pwdata[7:0]))
		else $error("delimiter readback mismatch");

	// registers are eight bits wide
	a_prdata_hi: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> prdata[31:8] == 24'd0)
		else $error("upper read data not zero");

endmodule

bind csv_field_tokenizer_unit csvft_checker u_csvft_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.token_kind (token_kind),
	.out_byte   (out_byte),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.pwdata     (pwdata),
	.prdata     (prdata)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import csvft_pkg::*;

	// one item offered to the tokenizer: a text byte or the end-of-input mark
	typedef struct packed {
		logic [7:0] chr;
		logic       eoi;
	} text_item_t;

	// one token as the tokenizer should emit it
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} token_exp_t;

	localparam int QUIET_LIMIT  = 3000;	// cycles with no handshake before giving up
	localparam int HOLD_CYCLES  = 300;	// long receiver hold-off under pressure
	localparam int PHASE_COUNT  = 9;
	localparam int RANDOM_ITEMS = 214;	// per phase, on top of the directed items

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'h00;
	logic        end_of_input = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  token_kind;
	logic [7:0]  out_byte;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	csv_field_tokenizer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_input(end_of_input),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.token_kind  (token_kind),
		.out_byte    (out_byte),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always #5 clk = ~clk;

	// Items waiting to be offered, and tokens still owed by the block
	text_item_t  text_queue[$];
	token_exp_t  token_queue[$];

	// Our own copy of the tokenizer's state and settings
	logic [2:0]  parse_state = PH_IDLE;
	logic [7:0]  delim_cfg = DELIMITER_RST;
	logic [7:0]  quote_cfg = QUOTE_RST;
	logic [7:0]  esc_cfg = ESCAPE_RST;

	int unsigned items_pushed = 0;
	int unsigned items_accepted = 0;
	int unsigned fail_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        pressure_req = 1'b0;
	logic        pressure_done = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	text_item_t  next_item;
	token_exp_t  want;

	// ------------------------------------------------------------------
	// Tokenizer prediction
	// ------------------------------------------------------------------
	function automatic void owe_token(input logic [1:0] kind, input logic [7:0] data);
		token_exp_t t;
		t.kind = kind;
		t.data = data;
		token_queue.push_back(t);
	endfunction

	// Unquoted field context. Priority: quote, delimiter, newline/end, escape, data.
	// A quote byte equal to the delimiter therefore opens a quoted section, and a
	// newline never escapes here.
	function automatic void field_context(input logic eoi, input logic [7:0] b);
		if (!eoi && b == quote_cfg) begin
			parse_state = PH_QUOTED;
		end else if (!eoi && b == delim_cfg) begin
			parse_state = PH_FIELD;
			owe_token(KIND_FIELD_END, 8'h00);
		end else if (eoi || b == NEWLINE_BYTE) begin
			parse_state = PH_IDLE;
			owe_token(KIND_REC_END, 8'h00);
		end else if (b == esc_cfg) begin
			parse_state = PH_FIELD_ESC;
		end else begin
			parse_state = PH_FIELD;
			owe_token(KIND_DATA, b);
		end
	endfunction

	function automatic void tokenize_step(input logic eoi, input logic [7:0] b);
		case (parse_state)
			PH_FIELD: begin
				field_context(eoi, b);
			end
			PH_FIELD_ESC, PH_QUOTED_ESC: begin
				// end straight after an escape is an error; otherwise take the byte
				if (eoi) begin
					parse_state = PH_IDLE;
					owe_token(KIND_ERROR, 8'h00);
				end else begin
					parse_state = (parse_state == PH_FIELD_ESC) ? PH_FIELD : PH_QUOTED;
					owe_token(KIND_DATA, b);
				end
			end
			PH_QUOTED: begin
				// inside quotes a newline or delimiter is plain data
				if (eoi) begin
					parse_state = PH_IDLE;
					owe_token(KIND_ERROR, 8'h00);
				end else if (b == quote_cfg) begin
					parse_state = PH_QUOTE_SEEN;
				end else if (b == esc_cfg) begin
					parse_state = PH_QUOTED_ESC;
				end else begin
					owe_token(KIND_DATA, b);
				end
			end
			PH_QUOTE_SEEN: begin
				// doubled quote gives a literal quote; anything else closes the section
				if (!eoi && b == quote_cfg) begin
					parse_state = PH_QUOTED;
					owe_token(KIND_DATA, b);
				end else begin
					field_context(eoi, b);
				end
			end
			default: begin
				// between records: end of input gives nothing
				parse_state = PH_IDLE;
				if (!eoi)
					field_context(1'b0, b);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic void add_item(input logic [7:0] b, input logic eoi);
		text_item_t t;
		t.chr = b;
		t.eoi = eoi;
		text_queue.push_back(t);
		items_pushed++;
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		add_item(b, 1'b0);
	endfunction

	// End mark with a random byte alongside, which the block must ignore
	function automatic void add_end();
		add_item(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	// Favour the bytes that steer the parser
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return delim_cfg;
			1: return quote_cfg;
			2: return esc_cfg;
			3: return NEWLINE_BYTE;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic is_special(input logic [7:0] b);
		return b == delim_cfg || b == quote_cfg || b == esc_cfg || b == NEWLINE_BYTE;
	endfunction

	// A well-formed record: fields with random content, quoted or not,
	// closed by a newline or, now and then, by the end of input
	function automatic void add_record();
		int unsigned nfields;
		int unsigned len;
		logic [7:0]  b;
		nfields = $urandom_range(1, 4);
		for (int f = 0; f < nfields; f++) begin
			if (f != 0)
				add_byte(delim_cfg);
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 2) == 0) begin
				add_byte(quote_cfg);
				for (int i = 0; i < len; i++) begin
					b = pick_byte();
					if (b == quote_cfg) begin
						add_byte(b);
						add_byte(b);
					end else if (b == esc_cfg) begin
						add_byte(esc_cfg);
						add_byte(8'($urandom_range(0, 255)));
					end else begin
						add_byte(b);
					end
				end
				add_byte(quote_cfg);
			end else begin
				for (int i = 0; i < len; i++) begin
					b = pick_byte();
					if (is_special(b))
						add_byte(esc_cfg);
					add_byte(b);
				end
			end
		end
		if ($urandom_range(0, 99) < 85)
			add_byte(NEWLINE_BYTE);
		else
			add_end();
	endfunction

	function automatic void add_noise(input int unsigned n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 8)
				add_end();
			else
				add_byte(pick_byte());
		end
	endfunction

	// Truncated sequences: end inside quotes or right after an escape
	function automatic void add_broken();
		if ($urandom_range(0, 1) == 0) begin
			add_byte(quote_cfg);
			add_noise($urandom_range(0, 3));
		end else begin
			add_byte(8'($urandom_range(0, 255)));
			add_byte(esc_cfg);
		end
		add_end();
	endfunction

	// ------------------------------------------------------------------
	// Sender: offer the next item, hold it while stalled, predict on accept
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				tokenize_step(end_of_input, in_byte);
				items_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_item = text_queue.pop_front();
					in_valid <= 1'b1;
					in_byte <= next_item.chr;
					end_of_input <= next_item.eoi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: compare each token with the oldest one owed, drive the stall
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (token_queue.size() == 0) begin
					$error("token with none owed: token_kind %0d out_byte %02h",
						token_kind, out_byte);
					fail_count++;
				end else begin
					want = token_queue.pop_front();
					if (token_kind !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, token_kind);
						fail_count++;
					end
					if (out_byte !== want.data) begin
						$error("out_byte: expected %02h, got %02h", want.data, out_byte);
						fail_count++;
					end
				end
			end
			// one long hold-off so the block fills and pushes back on the sender
			if (pressure_req && !pressure_done) begin
				hold_left = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Watchdog: give up after a long run of cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Sequencing: reset, then phases of settings, idling and stimulus
	// ------------------------------------------------------------------
	task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_DELIMITER: delim_cfg = val;
			REG_QUOTE:     quote_cfg = val;
			default:       esc_cfg = val;
		endcase
	endtask

	// Wait until every item is in and every owed token is out, then let the
	// pipeline settle so that a last item with no token is done as well
	task automatic drain();
		while (!(items_accepted == items_pushed && token_queue.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Settings per phase: odd clashes and the extremes, plus two random sets
	logic [7:0] plan_delim [PHASE_COUNT] = '{8'h2C, 8'h09, 8'h00, 8'hFF, 8'h2C, 8'h0A, 8'h00, 8'hFF, 8'h00};
	logic [7:0] plan_quote [PHASE_COUNT] = '{8'h22, 8'h27, 8'hFF, 8'h00, 8'h2C, 8'h22, 8'h00, 8'hFF, 8'h00};
	logic [7:0] plan_esc   [PHASE_COUNT] = '{8'h00, 8'h5C, 8'hFF, 8'h0A, 8'h5C, 8'h0A, 8'h00, 8'hFF, 8'h00};

	initial begin
		int unsigned phase_start;
		int unsigned r;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// idling pattern cycles: none, sender 60%, receiver 60%, both 28%
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 28; recv_stall_pct = 28; end
			endcase

			if (p != 0) begin
				// phases six and eight draw fresh random settings
				if (p == 6 || p == 8) begin
					reg_write(REG_DELIMITER, 8'($urandom_range(0, 255)));
					reg_write(REG_QUOTE, 8'($urandom_range(0, 255)));
					reg_write(REG_ESCAPE, 8'($urandom_range(0, 255)));
				end else begin
					reg_write(REG_DELIMITER, plan_delim[p]);
					reg_write(REG_QUOTE, plan_quote[p]);
					reg_write(REG_ESCAPE, plan_esc[p]);
				end
			end else begin
				// reset settings: directed walk over every token kind and corner
				add_end();                 // end between records: nothing
				add_byte(8'h61);           // data
				add_byte(delim_cfg);       // field end
				add_byte(8'hFF);           // top byte as data, not an end mark
				add_byte(esc_cfg);         // NUL escapes by default
				add_byte(NEWLINE_BYTE);    // escaped newline is data
				add_byte(NEWLINE_BYTE);    // record end
				add_byte(quote_cfg);       // open quotes
				add_byte(delim_cfg);       // delimiter in quotes is data
				add_byte(NEWLINE_BYTE);    // newline in quotes is data
				add_byte(quote_cfg);
				add_byte(quote_cfg);       // doubled quote gives a literal quote
				add_byte(esc_cfg);
				add_byte(quote_cfg);       // escaped quote in quotes
				add_byte(quote_cfg);       // close quotes
				add_end();                 // end after closing quote: record end
				add_byte(quote_cfg);
				add_end();                 // end inside quotes: error
				add_byte(8'h7A);
				add_byte(esc_cfg);
				add_end();                 // end after escape: error
				add_byte(quote_cfg);
				add_byte(quote_cfg);
				add_byte(delim_cfg);       // closing quote then delimiter
				add_end();
				// no idling here, so the long hold-off backs the block up
				pressure_req = 1'b1;
			end

			phase_start = items_pushed;
			while (items_pushed - phase_start < RANDOM_ITEMS) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					add_record();
				else if (r < 9)
					add_noise($urandom_range(1, 8));
				else
					add_broken();
			end
			drain();
		end

		repeat (6) @(posedge clk);
		if (token_queue.size() != 0) begin
			$error("%0d tokens never arrived", token_queue.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
